// ===== src/iic_pkg.sv =====
// shared constants, codes and the token type of the interval classifier chain
`default_nettype none
package iic_pkg;

   localparam int MAX_GROUPS = 256;
   localparam int IDX_W      = (MAX_GROUPS > 2) ? $clog2(MAX_GROUPS) : 1;
   localparam int CNT_W      = $clog2(MAX_GROUPS + 1);
   localparam int VAL_W      = 32;
   localparam int GRP_W      = 8;
   localparam int CMD_W      = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_APPEND   = 2'd1,
      CMD_CLASSIFY = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      TOK_IDLE     = 2'd0,
      TOK_APPEND   = 2'd1,
      TOK_CLASSIFY = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [VAL_W-1:0]     value;   // upper bound for append, value for classify
      logic [VAL_W-1:0]     lower;   // lower bound for append
      logic [IDX_W-1:0]     target;  // cell written by append
      logic [CNT_W-1:0]     count;   // groups present when classify entered
      logic                 found;
      logic [IDX_W-1:0]     match;
   } token_type;

endpackage
`default_nettype wire

// ===== src/iic_head.sv =====
// head of the chain: group count, running total and token injection
`default_nettype none
module iic_head (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic [iic_pkg::CMD_W-1:0] command,
   input  wire logic [iic_pkg::VAL_W-1:0] operand,
   output iic_pkg::token_type             tok_out
);
   import iic_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [VAL_W-1:0] total_ff, total_in;
   logic [VAL_W-1:0] sum;
   logic             full;

   assign sum  = total_ff + operand;
   assign full = (count_ff == CNT_W'(MAX_GROUPS));

   always_comb begin
      count_in       = count_ff;
      total_in       = total_ff;
      tok_out        = '0;
      tok_out.kind   = TOK_IDLE;
      tok_out.value  = operand;
      tok_out.lower  = total_ff;
      tok_out.target = count_ff[IDX_W-1:0];
      tok_out.count  = count_ff;
      if (accept) begin
         unique case (command)
            CMD_CLEAR: begin
               count_in = '0;
               total_in = '0;
            end
            CMD_APPEND: begin
               if (!full) begin
                  tok_out.kind  = TOK_APPEND;
                  tok_out.value = sum;
                  count_in      = count_ff + CNT_W'(1);
                  total_in      = sum;
               end
            end
            CMD_CLASSIFY: begin
               tok_out.kind = TOK_CLASSIFY;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/iic_cell.sv =====
// one chain cell: holds one group's bounds and checks passing classify tokens
`default_nettype none
module iic_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic [iic_pkg::IDX_W-1:0] cell_index,
   input  iic_pkg::token_type             tok_in,
   output iic_pkg::token_type             tok_out
);
   import iic_pkg::*;

   logic [VAL_W-1:0] lo_ff, hi_ff;
   token_type        tok_ff, tok_in_mod;
   logic             hit, write;

   assign write = (tok_in.kind == TOK_APPEND) && (tok_in.target == cell_index);
   assign hit   = (tok_in.kind == TOK_CLASSIFY) && !tok_in.found
                && (CNT_W'(cell_index) < tok_in.count)
                && (tok_in.value >= lo_ff) && (tok_in.value < hi_ff);

   always_comb begin
      tok_in_mod = tok_in;
      if (hit) begin
         tok_in_mod.found = 1'b1;
         tok_in_mod.match = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && write) begin
         lo_ff <= tok_in.lower;
         hi_ff <= tok_in.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.kind <= TOK_IDLE;
      end else if (advance) begin
         tok_ff <= tok_in_mod;
      end
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

// ===== src/interval_index_classifier_core.sv =====
// Interval index classifier: a row of MAX_GROUPS cells, one per group, each
// holding its group's lower and upper bound. Every request walks the row one
// cell per cycle while no response is stalled, so one request is taken each such
// cycle; a classify answer passes every cell and the response register before it
// shows on rsp_tvalid. Appends write their cell on the way and clears act at the
// head. A stalled response holds the whole row and drops req_tready.
`default_nettype none
module interval_index_classifier_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [iic_pkg::VAL_W-1:0] req_tdata,   // operand
   input  wire logic [iic_pkg::CMD_W-1:0] req_tuser,   // command
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [iic_pkg::GRP_W-1:0]      rsp_tdata,   // group_index
   output logic                           rsp_tuser    // found
);
   import iic_pkg::*;

   token_type        chain [MAX_GROUPS+1];
   logic             advance;
   logic             rsp_valid_ff;
   logic [GRP_W-1:0] rsp_index_ff;
   logic             rsp_found_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   iic_head u_head (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_tvalid && advance),
      .command (req_tuser),
      .operand (req_tdata),
      .tok_out (chain[0])
   );

   for (genvar g = 0; g < MAX_GROUPS; g++) begin : g_cell
      iic_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (IDX_W'(g)),
         .tok_in     (chain[g]),
         .tok_out    (chain[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= (chain[MAX_GROUPS].kind == TOK_CLASSIFY);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_found_ff <= chain[MAX_GROUPS].found;
         rsp_index_ff <= chain[MAX_GROUPS].found ? GRP_W'(chain[MAX_GROUPS].match) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule
`default_nettype wire

// ===== src/iic_checker.sv =====
// port-level checks for the interval classifier and their bind
`default_nettype none
module iic_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [iic_pkg::GRP_W-1:0] rsp_tdata,
   input wire logic                      rsp_tuser
);
   import iic_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero group index");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response right after reset");

   a_ready_free: assert property (@(posedge clock)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with no response pending");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

endmodule

bind interval_index_classifier_core iic_checker u_iic_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
// self-checking testbench for the interval index classifier core
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import iic_pkg::*;

   localparam int          RANDOM_ITEMS = 1650;
   localparam int          STALL_LIMIT  = 5000;
   localparam int          DRAIN_CYCLES = MAX_GROUPS + 40;
   localparam int          HOLD_CYCLES  = 700;
   localparam int          HOLD_AT      = 400;
   localparam int          MODE_SPAN    = 150;
   localparam logic [1:0]  CMD_RESERVED = 2'd3;

   localparam int MODE_FREE        = 0;
   localparam int MODE_SEND_GAPS   = 1;
   localparam int MODE_RECV_STALLS = 2;
   localparam int MODE_BOTH        = 3;

   typedef struct packed {
      logic [GRP_W-1:0] grp;
      logic             hit;
   } lookup_answer_type;

   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic [VAL_W-1:0] operand;
      logic             typed;
      logic [GRP_W-1:0] grp;
      logic             hit;
   } probe_row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [VAL_W-1:0]  req_tdata;   // operand
   logic [CMD_W-1:0]  req_tuser;   // command
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [GRP_W-1:0]  rsp_tdata;   // group_index
   logic              rsp_tuser;   // found

   logic [VAL_W-1:0]  bound_table [MAX_GROUPS];
   int                group_total;
   lookup_answer_type pending_answers [$];
   lookup_answer_type head_answer;
   int                errors;
   int                n_sent;
   int                n_counted;
   int                quiet_cycles;
   int                hold_left;
   bit                hold_done;
   bit                stimulus_done;

   probe_row_type directed_rows [23] = '{
      '{CMD_CLASSIFY, 32'd0,          1'b1, 8'd0, 1'b0},   // empty table
      '{CMD_CLASSIFY, 32'hFFFF_FFFF,  1'b1, 8'd0, 1'b0},
      '{CMD_APPEND,   32'd10,         1'b0, 8'd0, 1'b0},
      '{CMD_CLASSIFY, 32'd0,          1'b1, 8'd0, 1'b1},
      '{CMD_CLASSIFY, 32'd9,          1'b1, 8'd0, 1'b1},
      '{CMD_CLASSIFY, 32'd10,         1'b1, 8'd0, 1'b0},
      '{CMD_APPEND,   32'd0,          1'b0, 8'd0, 1'b0},   // empty group
      '{CMD_APPEND,   32'd5,          1'b0, 8'd0, 1'b0},
      '{CMD_CLASSIFY, 32'd10,         1'b1, 8'd2, 1'b1},
      '{CMD_CLASSIFY, 32'd14,         1'b1, 8'd2, 1'b1},
      '{CMD_RESERVED, 32'd100,        1'b0, 8'd0, 1'b0},
      '{CMD_CLASSIFY, 32'd15,         1'b1, 8'd0, 1'b0},
      '{CMD_APPEND,   32'hFFFF_FFFF,  1'b0, 8'd0, 1'b0},   // wraps, inverted group
      '{CMD_APPEND,   32'd100,        1'b0, 8'd0, 1'b0},
      '{CMD_CLASSIFY, 32'd14,         1'b1, 8'd2, 1'b1},
      '{CMD_CLASSIFY, 32'd20,         1'b1, 8'd4, 1'b1},
      '{CMD_CLASSIFY, 32'hFFFF_FFFF,  1'b1, 8'd0, 1'b0},
      '{CMD_CLEAR,    32'hFFFF_FFFF,  1'b0, 8'd0, 1'b0},
      '{CMD_CLASSIFY, 32'd5,          1'b1, 8'd0, 1'b0},
      '{CMD_APPEND,   32'hFFFF_FFFF,  1'b0, 8'd0, 1'b0},
      '{CMD_CLASSIFY, 32'hFFFF_FFFE,  1'b1, 8'd0, 1'b1},
      '{CMD_CLASSIFY, 32'hFFFF_FFFF,  1'b1, 8'd0, 1'b0},
      '{CMD_CLEAR,    32'd0,          1'b0, 8'd0, 1'b0}
   };

   interval_index_classifier_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic int idle_mode();
      if (stimulus_done) return MODE_FREE;
      return (n_sent / MODE_SPAN) % 4;
   endfunction

   function automatic logic [VAL_W-1:0] group_floor(int j);
      return (j == 0) ? '0 : bound_table[j-1];
   endfunction

   function automatic lookup_answer_type classify_value(logic [VAL_W-1:0] v);
      lookup_answer_type ans;
      ans = '0;
      for (int j = 0; j < group_total; j++) begin
         if (v >= group_floor(j) && v < bound_table[j]) begin
            ans.grp = j[GRP_W-1:0];
            ans.hit = 1'b1;
            return ans;
         end
      end
      return ans;
   endfunction

   function automatic logic [VAL_W-1:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(1, 1000);
      if (r < 75) return '0;
      if (r < 90) return $urandom_range(0, 32'h00FF_FFFF);
      return $urandom;
   endfunction

   function automatic logic [VAL_W-1:0] pick_probe();
      int               r;
      int               j;
      logic [VAL_W-1:0] lo;
      logic [VAL_W-1:0] hi;
      r = $urandom_range(9);
      if (group_total == 0 || r == 6 || r == 7) return $urandom;
      if (r == 8) return '0;
      if (r == 9) return '1;
      j  = (r == 4) ? group_total - 1 : $urandom_range(0, group_total - 1);
      lo = group_floor(j);
      hi = bound_table[j];
      if (r == 5) return hi;
      if (hi <= lo) return lo;
      if (r == 4 || r == 3) return hi - 1;
      return $urandom_range(lo, hi - 1);
   endfunction

   // offer one request and update the predictor once it is taken
   task automatic issue(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] operand,
                        input logic typed, input lookup_answer_type typed_ans);
      int gap;
      gap = (idle_mode() == MODE_SEND_GAPS) ? 59 : (idle_mode() == MODE_BOTH) ? 10 : 0;
      while ($urandom_range(99) < gap) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= CMD_W'($urandom_range(0, 3));
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= operand;
      req_tuser  <= op;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      case (op)
         CMD_CLEAR: group_total = 0;
         CMD_APPEND: begin
            if (group_total < MAX_GROUPS) begin
               bound_table[group_total] = group_floor(group_total) + operand;
               group_total++;
            end
         end
         CMD_CLASSIFY: pending_answers.insert(pending_answers.size(),
                                              typed ? typed_ans : classify_value(operand));
         default: ;
      endcase
      n_sent++;
      if (op != CMD_RESERVED) n_counted++;
      @(negedge clock);
   endtask

   // random part: mostly table builds followed by probes, some raw noise
   task automatic run_random();
      int  n_app;
      bit  first;
      first = 1'b1;
      while (n_counted < RANDOM_ITEMS + $size(directed_rows)) begin
         if ($urandom_range(99) < 85) begin
            if (first || $urandom_range(99) < 6)
               n_app = MAX_GROUPS + $urandom_range(1, 8);
            else
               n_app = $urandom_range(0, 20);
            first = 1'b0;
            if ($urandom_range(3) != 0) issue(CMD_CLEAR, $urandom, 1'b0, '0);
            repeat (n_app) issue(CMD_APPEND, pick_size(), 1'b0, '0);
            repeat ($urandom_range(1, 30)) issue(CMD_CLASSIFY, pick_probe(), 1'b0, '0);
         end else begin
            repeat ($urandom_range(1, 6))
               issue(CMD_W'($urandom_range(0, 3)), $urandom, 1'b0, '0);
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = CMD_CLEAR;
      group_total   = 0;
      errors        = 0;
      n_sent        = 0;
      n_counted     = 0;
      stimulus_done = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed_rows[i])
         issue(directed_rows[i].op, directed_rows[i].operand, directed_rows[i].typed,
               '{directed_rows[i].grp, directed_rows[i].hit});
      run_random();
      req_tvalid    <= 1'b0;
      stimulus_done = 1'b1;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // response side backpressure, with one long hold-off while requests keep coming
   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && n_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (idle_mode() == MODE_RECV_STALLS) begin
            rsp_tready <= ($urandom_range(99) >= 59);
         end else if (idle_mode() == MODE_BOTH) begin
            rsp_tready <= ($urandom_range(99) >= 10);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            errors++;
            $display("%0t: response with nothing outstanding, got index %0d found %0b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            head_answer = pending_answers.pop_front();
            if (rsp_tdata !== head_answer.grp) begin
               errors++;
               $display("%0t: group_index expected %0d got %0d",
                        $time, head_answer.grp, rsp_tdata);
            end
            if (rsp_tuser !== head_answer.hit) begin
               errors++;
               $display("%0t: found expected %0b got %0b", $time, head_answer.hit, rsp_tuser);
            end
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule
